// ===== rtl/eegpp_pkg.sv =====
// Shared types and constants for the EEG headset serial packet parser.
// No dependencies; imported by every module of the block but the checker, and by the bench.
package eegpp_pkg;

   localparam int unsigned BYTE_W          = 8;
   localparam int unsigned NUM_BYTE_ROWS   = 4;
   localparam int unsigned POWER_ROW_BYTES = 26;
   localparam int unsigned ROW_LEFT_W      = 5;
   localparam int unsigned CSR_INDEX_W     = 3;

   localparam logic [ROW_LEFT_W-1:0] POWER_SKIP = ROW_LEFT_W'(POWER_ROW_BYTES - 1);
   localparam logic [BYTE_W-1:0]     CSUM_MASK  = 8'hFF;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SYNC       = 3'd0,
      REG_MAX_LEN    = 3'd1,
      REG_RAW        = 3'd2,
      REG_QUALITY    = 3'd3,
      REG_ATTENTION  = 3'd4,
      REG_MEDITATION = 3'd5,
      REG_BLINK      = 3'd6,
      REG_POWER      = 3'd7
   } reg_index_type;

   typedef enum logic [4:0] {
      PH_HUNT1   = 5'b00001,
      PH_HUNT2   = 5'b00010,
      PH_LEN     = 5'b00100,
      PH_PAYLOAD = 5'b01000,
      PH_CHECK   = 5'b10000
   } phase_type;

   typedef enum logic [5:0] {
      RK_CODE   = 6'b000001,
      RK_RAWLEN = 6'b000010,
      RK_RAWHI  = 6'b000100,
      RK_RAWLO  = 6'b001000,
      RK_VALUE  = 6'b010000,
      RK_SKIP   = 6'b100000
   } row_kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0] sync_byte;
      logic [BYTE_W-1:0] max_payload;
      logic [BYTE_W-1:0] raw_code;
      logic [BYTE_W-1:0] quality_code;
      logic [BYTE_W-1:0] attn_code;
      logic [BYTE_W-1:0] medit_code;
      logic [BYTE_W-1:0] blink_code;
      logic [BYTE_W-1:0] power_code;
   } cfg_type;

   typedef struct packed {
      logic [15:0]                          raw;
      logic [NUM_BYTE_ROWS-1:0][BYTE_W-1:0] bytes;
      logic [NUM_BYTE_ROWS:0]               valid;   // bit 0 raw, then the byte rows
   } shadow_type;

   typedef struct packed {
      logic signed [15:0] raw_sample;
      logic               raw_valid;
      logic [BYTE_W-1:0]  quality_level;
      logic               quality_valid;
      logic [BYTE_W-1:0]  attention_level;
      logic               attention_valid;
      logic [BYTE_W-1:0]  meditation_level;
      logic               meditation_valid;
      logic [BYTE_W-1:0]  blink_level;
      logic               blink_valid;
      logic               checksum_error;
   } rsp_type;

endpackage

// ===== rtl/eegpp_rows.sv =====
// Payload row decoder: tracks the row in progress and fills the shadow values.
// Depends on eegpp_pkg.
module eegpp_rows (
   input  logic                 clock,
   input  logic                 reset,
   input  eegpp_pkg::cfg_type   cfg,
   input  logic                 clear,
   input  logic                 byte_en,
   input  logic [7:0]           rx_byte,
   output eegpp_pkg::shadow_type shadow
);
   import eegpp_pkg::*;

   row_kind_type                       kind_ff, kind_in;
   logic [ROW_LEFT_W-1:0]              left_ff, left_in;
   logic [BYTE_W-1:0]                  high_ff, high_in;
   logic [15:0]                        raw_ff, raw_in;
   logic [NUM_BYTE_ROWS-1:0][BYTE_W-1:0] bytes_ff, bytes_in;
   logic [NUM_BYTE_ROWS:0]             valid_ff, valid_in;
   logic [ROW_LEFT_W-1:0]              left_dec;

   assign left_dec = (left_ff != '0) ? left_ff - ROW_LEFT_W'(1) : left_ff;

   always_comb begin
      kind_in  = kind_ff;
      left_in  = left_ff;
      high_in  = high_ff;
      raw_in   = raw_ff;
      bytes_in = bytes_ff;
      valid_in = valid_ff;
      if (clear) begin
         kind_in  = RK_CODE;
         left_in  = '0;
         valid_in = '0;
      end else if (byte_en) begin
         unique case (kind_ff)
            RK_RAWLEN: kind_in = RK_RAWHI;
            RK_RAWHI: begin
               high_in = rx_byte;
               kind_in = RK_RAWLO;
            end
            RK_RAWLO: begin
               raw_in      = {high_ff, rx_byte};
               valid_in[0] = 1'b1;
               kind_in     = RK_CODE;
            end
            RK_VALUE: begin
               bytes_in[left_ff[1:0]]                 = rx_byte;
               valid_in[{1'b0, left_ff[1:0]} + 3'd1] = 1'b1;
               kind_in                                = RK_CODE;
               left_in                                = '0;
            end
            RK_SKIP: begin
               left_in = left_dec;
               if (left_dec == '0) kind_in = RK_CODE;
            end
            RK_CODE: begin
               priority if (rx_byte == cfg.raw_code) begin
                  kind_in = RK_RAWLEN;
               end else if (rx_byte == cfg.quality_code) begin
                  kind_in = RK_VALUE;
                  left_in = ROW_LEFT_W'(0);
               end else if (rx_byte == cfg.attn_code) begin
                  kind_in = RK_VALUE;
                  left_in = ROW_LEFT_W'(1);
               end else if (rx_byte == cfg.medit_code) begin
                  kind_in = RK_VALUE;
                  left_in = ROW_LEFT_W'(2);
               end else if (rx_byte == cfg.blink_code) begin
                  kind_in = RK_VALUE;
                  left_in = ROW_LEFT_W'(3);
               end else if (rx_byte == cfg.power_code) begin
                  kind_in = RK_SKIP;
                  left_in = POWER_SKIP;
               end else begin
                  kind_in = RK_CODE;
               end
            end
            default: kind_in = RK_CODE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff  <= RK_CODE;
         left_ff  <= '0;
         valid_ff <= '0;
      end else begin
         kind_ff  <= kind_in;
         left_ff  <= left_in;
         valid_ff <= valid_in;
      end
      high_ff  <= high_in;
      raw_ff   <= raw_in;
      bytes_ff <= bytes_in;
   end

   assign shadow = '{raw: raw_ff, bytes: bytes_ff, valid: valid_ff};

endmodule

// ===== rtl/eegpp_frame.sv =====
// Frame tracker: sync hunt, length check, payload count, checksum and result build.
// Depends on eegpp_pkg and eegpp_rows.
module eegpp_frame (
   input  logic               clock,
   input  logic               reset,
   input  eegpp_pkg::cfg_type cfg,
   input  logic               byte_fire,
   input  logic [7:0]         rx_byte,
   output logic               at_check,
   output logic               result_valid,
   output eegpp_pkg::rsp_type result
);
   import eegpp_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [BYTE_W-1:0] count_ff, count_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic              rows_clear;
   logic              rows_en;
   shadow_type        shadow;

   eegpp_rows u_rows (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .clear   (rows_clear),
      .byte_en (rows_en),
      .rx_byte (rx_byte),
      .shadow  (shadow)
   );

   assign at_check = (phase_ff == PH_CHECK);

   always_comb begin
      phase_in     = phase_ff;
      len_in       = len_ff;
      count_in     = count_ff;
      sum_in       = sum_ff;
      rows_clear   = 1'b0;
      rows_en      = 1'b0;
      result_valid = 1'b0;
      result       = '0;
      if (byte_fire) begin
         unique case (phase_ff)
            PH_HUNT1: if (rx_byte == cfg.sync_byte) phase_in = PH_HUNT2;
            PH_HUNT2: phase_in = (rx_byte == cfg.sync_byte) ? PH_LEN : PH_HUNT1;
            PH_LEN: begin
               if (rx_byte == cfg.sync_byte) begin
                  phase_in = PH_LEN;
               end else if (rx_byte > cfg.max_payload) begin
                  phase_in = PH_HUNT1;
               end else begin
                  len_in     = rx_byte;
                  count_in   = '0;
                  sum_in     = '0;
                  rows_clear = 1'b1;
                  phase_in   = (rx_byte == '0) ? PH_CHECK : PH_PAYLOAD;
               end
            end
            PH_PAYLOAD: begin
               sum_in   = sum_ff + rx_byte;
               count_in = count_ff + BYTE_W'(1);
               rows_en  = 1'b1;
               if (count_in >= len_ff) phase_in = PH_CHECK;
            end
            PH_CHECK: begin
               phase_in     = PH_HUNT1;
               result_valid = 1'b1;
               if ((~sum_ff & CSUM_MASK) != rx_byte) begin
                  result.checksum_error = 1'b1;
               end else begin
                  result.raw_valid        = shadow.valid[0];
                  result.raw_sample       = shadow.valid[0] ? signed'(shadow.raw) : '0;
                  result.quality_valid    = shadow.valid[1];
                  result.quality_level    = shadow.valid[1] ? shadow.bytes[0] : '0;
                  result.attention_valid  = shadow.valid[2];
                  result.attention_level  = shadow.valid[2] ? shadow.bytes[1] : '0;
                  result.meditation_valid = shadow.valid[3];
                  result.meditation_level = shadow.valid[3] ? shadow.bytes[2] : '0;
                  result.blink_valid      = shadow.valid[4];
                  result.blink_level      = shadow.valid[4] ? shadow.bytes[3] : '0;
               end
            end
            default: phase_in = PH_HUNT1;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT1;
         len_ff   <= '0;
         count_ff <= '0;
         sum_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         len_ff   <= len_in;
         count_ff <= count_in;
         sum_ff   <= sum_in;
      end
   end

endmodule

// ===== rtl/eeg_headset_packet_parser.sv =====
// Top level of the EEG headset serial packet parser: register file, frame tracker,
// result register and handshake. Depends on eegpp_pkg and eegpp_frame.
//
//   channel  dir   ports                      carries
//   req      in    req_valid/req_ready        one received byte (word) per handshake
//   rsp      out   rsp_valid/rsp_ready        one frame result word per checksum byte
//   csr      in    csr_write_en/index/wdata   register writes, no wait
//
// One word is taken per cycle unless stalled; a result shows on rsp the cycle after
// the checksum byte is taken. While a result waits on rsp, non-checksum bytes keep
// flowing; only a checksum byte stalls until the pending result is taken. Synchronous
// reset puts registers at defaults and the tracker in sync hunt; no clearing pass.
module eeg_headset_packet_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_raw_sample,
   output logic               rsp_raw_valid,
   output logic [7:0]         rsp_quality_level,
   output logic               rsp_quality_valid,
   output logic [7:0]         rsp_attention_level,
   output logic               rsp_attention_valid,
   output logic [7:0]         rsp_meditation_level,
   output logic               rsp_meditation_valid,
   output logic [7:0]         rsp_blink_level,
   output logic               rsp_blink_valid,
   output logic               rsp_checksum_error,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [7:0]         csr_wdata
);
   import eegpp_pkg::*;

   cfg_type cfg_ff, cfg_in;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    at_check;
   logic    result_valid;
   rsp_type result;
   logic    req_fire;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (reg_index_type'(csr_index))
            REG_SYNC:       cfg_in.sync_byte    = csr_wdata;
            REG_MAX_LEN:    cfg_in.max_payload  = csr_wdata;
            REG_RAW:        cfg_in.raw_code     = csr_wdata;
            REG_QUALITY:    cfg_in.quality_code = csr_wdata;
            REG_ATTENTION:  cfg_in.attn_code    = csr_wdata;
            REG_MEDITATION: cfg_in.medit_code   = csr_wdata;
            REG_BLINK:      cfg_in.blink_code   = csr_wdata;
            REG_POWER:      cfg_in.power_code   = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   assign req_ready = !at_check || !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   eegpp_frame u_frame (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .byte_fire    (req_fire),
      .rx_byte      (req_rx_byte),
      .at_check     (at_check),
      .result_valid (result_valid),
      .result       (result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (result_valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '{sync_byte: 8'd170, max_payload: 8'd169, raw_code: 8'd128,
                           quality_code: 8'd2, attn_code: 8'd4,
                           medit_code: 8'd5, blink_code: 8'd22,
                           power_code: 8'd131};
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_raw_sample       = rsp_data_ff.raw_sample;
   assign rsp_raw_valid        = rsp_data_ff.raw_valid;
   assign rsp_quality_level    = rsp_data_ff.quality_level;
   assign rsp_quality_valid    = rsp_data_ff.quality_valid;
   assign rsp_attention_level  = rsp_data_ff.attention_level;
   assign rsp_attention_valid  = rsp_data_ff.attention_valid;
   assign rsp_meditation_level = rsp_data_ff.meditation_level;
   assign rsp_meditation_valid = rsp_data_ff.meditation_valid;
   assign rsp_blink_level      = rsp_data_ff.blink_level;
   assign rsp_blink_valid      = rsp_data_ff.blink_valid;
   assign rsp_checksum_error   = rsp_data_ff.checksum_error;

endmodule

// ===== rtl/eegpp_checker.sv =====
// Port-level checks for the EEG headset serial packet parser, bound to its top level.
// No package dependency.
module eegpp_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] rsp_raw_sample,
   input logic               rsp_raw_valid,
   input logic [7:0]         rsp_quality_level,
   input logic               rsp_quality_valid,
   input logic [7:0]         rsp_attention_level,
   input logic               rsp_attention_valid,
   input logic [7:0]         rsp_meditation_level,
   input logic               rsp_meditation_valid,
   input logic [7:0]         rsp_blink_level,
   input logic               rsp_blink_valid,
   input logic               rsp_checksum_error
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_raw_sample)
         && $stable(rsp_checksum_error) && $stable(rsp_quality_level))
      else $error("result word changed while stalled");

   a_new_rsp_needs_byte: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready))
      else $error("result word without a taken byte");

   a_error_clears_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_checksum_error |-> !rsp_raw_valid && !rsp_quality_valid
         && !rsp_attention_valid && !rsp_meditation_valid && !rsp_blink_valid)
      else $error("valid flag set on checksum error");

   a_invalid_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_raw_valid || rsp_raw_sample == 16'sd0)
         && (rsp_quality_valid || rsp_quality_level == 8'd0)
         && (rsp_attention_valid || rsp_attention_level == 8'd0)
         && (rsp_meditation_valid || rsp_meditation_level == 8'd0)
         && (rsp_blink_valid || rsp_blink_level == 8'd0))
      else $error("field without its row is nonzero");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

endmodule

bind eeg_headset_packet_parser eegpp_checker u_eegpp_checker (.*);

// ===== bench/eeg_headset_packet_parser_check.sv =====
// Frame decoder model and result checker for the EEG headset packet parser.
// Watches the req, rsp and csr ports of the block; depends on eegpp_pkg.
module eeg_headset_packet_parser_check #(
   parameter eegpp_pkg::cfg_type RESET_CFG = '0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [7:0]         req_rx_byte,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_raw_sample,
   input  logic               rsp_raw_valid,
   input  logic [7:0]         rsp_quality_level,
   input  logic               rsp_quality_valid,
   input  logic [7:0]         rsp_attention_level,
   input  logic               rsp_attention_valid,
   input  logic [7:0]         rsp_meditation_level,
   input  logic               rsp_meditation_valid,
   input  logic [7:0]         rsp_blink_level,
   input  logic               rsp_blink_valid,
   input  logic               rsp_checksum_error,
   input  logic               csr_write_en,
   input  logic [2:0]         csr_index,
   input  logic [7:0]         csr_wdata,
   output int                 results_due,
   output int                 mismatches
);
   import eegpp_pkg::*;

   typedef enum logic [1:0] {
      ROW_QUALITY,
      ROW_ATTENTION,
      ROW_MEDITATION,
      ROW_BLINK
   } byte_row_type;

   localparam int SHOWN_MISMATCHES = 10;

   cfg_type       cfg;
   phase_type     phase;
   row_kind_type  row_kind;
   byte_row_type  value_row;
   logic [4:0]    skip_left;
   logic [7:0]    frame_len;
   logic [7:0]    frame_count;
   logic [7:0]    frame_sum;
   logic [7:0]    sample_high;
   shadow_type    sh;
   rsp_type       frame_results_due[$];
   rsp_type       seen;
   rsp_type       due;

   function automatic string show(input rsp_type r);
      return $sformatf("raw %0d/%0b qual %0d/%0b att %0d/%0b med %0d/%0b blink %0d/%0b err %0b",
                       r.raw_sample, r.raw_valid, r.quality_level, r.quality_valid,
                       r.attention_level, r.attention_valid, r.meditation_level,
                       r.meditation_valid, r.blink_level, r.blink_valid,
                       r.checksum_error);
   endfunction

   task automatic take_row_byte(input logic [7:0] b);
      case (row_kind)
         RK_RAWLEN: row_kind = RK_RAWHI;
         RK_RAWHI: begin
            sample_high = b;
            row_kind    = RK_RAWLO;
         end
         RK_RAWLO: begin
            sh.raw      = {sample_high, b};
            sh.valid[0] = 1'b1;
            row_kind    = RK_CODE;
         end
         RK_VALUE: begin
            sh.bytes[value_row]              = b;
            sh.valid[int'(value_row) + 1] = 1'b1;
            row_kind                         = RK_CODE;
         end
         RK_SKIP: begin
            if (skip_left > 0) skip_left--;
            if (skip_left == 0) row_kind = RK_CODE;
         end
         default: begin
            // priority: raw, quality, attention, meditation, blink, power
            row_kind = RK_VALUE;
            if (b == cfg.raw_code) row_kind = RK_RAWLEN;
            else if (b == cfg.quality_code) value_row = ROW_QUALITY;
            else if (b == cfg.attn_code) value_row = ROW_ATTENTION;
            else if (b == cfg.medit_code) value_row = ROW_MEDITATION;
            else if (b == cfg.blink_code) value_row = ROW_BLINK;
            else if (b == cfg.power_code) begin
               row_kind  = RK_SKIP;
               skip_left = POWER_SKIP;
            end else begin
               row_kind = RK_CODE;
            end
         end
      endcase
   endtask

   task automatic decode_rx_byte(input logic [7:0] b);
      rsp_type r;
      r = '0;
      case (phase)
         PH_HUNT1: if (b == cfg.sync_byte) phase = PH_HUNT2;
         PH_HUNT2: phase = (b == cfg.sync_byte) ? PH_LEN : PH_HUNT1;
         PH_LEN: begin
            if (b != cfg.sync_byte) begin
               if (b > cfg.max_payload) begin
                  phase = PH_HUNT1;
               end else begin
                  frame_len   = b;
                  frame_count = '0;
                  frame_sum   = '0;
                  row_kind    = RK_CODE;
                  skip_left   = '0;
                  sample_high = '0;
                  sh          = '0;
                  phase       = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
               end
            end
         end
         PH_PAYLOAD: begin
            frame_sum += b;
            frame_count++;
            take_row_byte(b);
            if (frame_count >= frame_len) phase = PH_CHECK;
         end
         PH_CHECK: begin
            phase = PH_HUNT1;
            if (~frame_sum != b) begin
               r.checksum_error = 1'b1;
            end else begin
               r.raw_valid        = sh.valid[0];
               r.raw_sample       = sh.valid[0] ? sh.raw : '0;
               r.quality_valid    = sh.valid[1];
               r.quality_level    = sh.valid[1] ? sh.bytes[ROW_QUALITY] : '0;
               r.attention_valid  = sh.valid[2];
               r.attention_level  = sh.valid[2] ? sh.bytes[ROW_ATTENTION] : '0;
               r.meditation_valid = sh.valid[3];
               r.meditation_level = sh.valid[3] ? sh.bytes[ROW_MEDITATION] : '0;
               r.blink_valid      = sh.valid[4];
               r.blink_level      = sh.valid[4] ? sh.bytes[ROW_BLINK] : '0;
            end
            frame_results_due.push_back(r);
         end
         default: phase = PH_HUNT1;
      endcase
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg         = RESET_CFG;
         phase       = PH_HUNT1;
         row_kind    = RK_CODE;
         value_row   = ROW_QUALITY;
         skip_left   = '0;
         frame_len   = '0;
         frame_count = '0;
         frame_sum   = '0;
         sample_high = '0;
         sh          = '0;
         frame_results_due.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_SYNC:       cfg.sync_byte    = csr_wdata;
               REG_MAX_LEN:    cfg.max_payload  = csr_wdata;
               REG_RAW:        cfg.raw_code     = csr_wdata;
               REG_QUALITY:    cfg.quality_code = csr_wdata;
               REG_ATTENTION:  cfg.attn_code    = csr_wdata;
               REG_MEDITATION: cfg.medit_code   = csr_wdata;
               REG_BLINK:      cfg.blink_code   = csr_wdata;
               REG_POWER:      cfg.power_code   = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            seen = '{rsp_raw_sample, rsp_raw_valid, rsp_quality_level, rsp_quality_valid,
                     rsp_attention_level, rsp_attention_valid, rsp_meditation_level,
                     rsp_meditation_valid, rsp_blink_level, rsp_blink_valid,
                     rsp_checksum_error};
            if (frame_results_due.size() == 0) begin
               if (mismatches < SHOWN_MISMATCHES)
                  $display("%0t: result word with none expected: %s", $realtime, show(seen));
               mismatches++;
            end else begin
               due = frame_results_due.pop_front();
               if (seen !== due) begin
                  if (mismatches < SHOWN_MISMATCHES) begin
                     $display("%0t: result word mismatch", $realtime);
                     $display("   expected %s", show(due));
                     $display("   actual   %s", show(seen));
                  end
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) decode_rx_byte(req_rx_byte);
      end
      results_due = frame_results_due.size();
   end

endmodule

// ===== bench/eeg_headset_packet_parser_test.sv =====
// Top of the EEG headset packet parser testbench: clock, reset, byte stream and
// register settings, verdict. Depends on eegpp_pkg, the block and its checker.
module eeg_headset_packet_parser_test;
   import eegpp_pkg::*;

   localparam cfg_type RESET_CFG = '{sync_byte: 8'd170, max_payload: 8'd169,
                                     raw_code: 8'd128, quality_code: 8'd2,
                                     attn_code: 8'd4, medit_code: 8'd5,
                                     blink_code: 8'd22, power_code: 8'd131};
   localparam int NUM_REGS       = $bits(cfg_type) / BYTE_W;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 2000;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_rx_byte;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [15:0] rsp_raw_sample;
   logic               rsp_raw_valid;
   logic [7:0]         rsp_quality_level;
   logic               rsp_quality_valid;
   logic [7:0]         rsp_attention_level;
   logic               rsp_attention_valid;
   logic [7:0]         rsp_meditation_level;
   logic               rsp_meditation_valid;
   logic [7:0]         rsp_blink_level;
   logic               rsp_blink_valid;
   logic               rsp_checksum_error;
   logic               csr_write_en;
   logic [2:0]         csr_index;
   logic [7:0]         csr_wdata;
   int                 results_due;
   int                 mismatches;

   cfg_type    cfg;
   cfg_type    next_cfg;
   logic [7:0] payload[$];
   int         sent_bytes;
   int         tx_idle_pct;
   int         rx_idle_pct;
   int         quiet_cycles;

   eeg_headset_packet_parser u_dut (.*);

   eeg_headset_packet_parser_check #(.RESET_CFG(RESET_CFG)) u_check (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("eeg_headset_packet_parser regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      @(negedge clock);
      sent_bytes++;
   endtask

   task automatic send_frame(input bit corrupt, input int extra_syncs);
      logic [7:0] sum;
      sum = '0;
      foreach (payload[i]) sum += payload[i];
      send_byte(cfg.sync_byte);
      send_byte(cfg.sync_byte);
      repeat (extra_syncs) send_byte(cfg.sync_byte);
      send_byte(8'(payload.size()));
      foreach (payload[i]) send_byte(payload[i]);
      send_byte(corrupt ? ~sum ^ 8'($urandom_range(255, 1)) : ~sum);
   endtask

   task automatic random_frame();
      int         len;
      int         pick;
      logic [7:0] b;
      logic [15:0] smp;
      pick = $urandom_range(15);
      if (pick == 0) begin
         repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
      end else if (pick == 1) begin
         b = 8'($urandom);
         if (b == cfg.sync_byte) b = ~b;
         send_byte(cfg.sync_byte);
         send_byte(b);
      end else if (pick == 2 && cfg.max_payload < 8'hFF) begin
         send_byte(cfg.sync_byte);
         send_byte(cfg.sync_byte);
         send_byte(8'($urandom_range(255, int'(cfg.max_payload) + 1)));
      end
      if ($urandom_range(29) == 0) len = $urandom_range(cfg.max_payload);
      else len = $urandom_range(cfg.max_payload < 20 ? cfg.max_payload : 20);
      if (len == cfg.sync_byte) len = (len > 0) ? len - 1 : 1;
      payload.delete();
      while (payload.size() < len) begin
         case ($urandom_range(9))
            0, 1: begin
               smp = 16'($urandom);
               if ($urandom_range(3) == 0) smp = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
               payload.push_back(cfg.raw_code);
               payload.push_back(8'($urandom));
               payload.push_back(smp[15:8]);
               payload.push_back(smp[7:0]);
            end
            2, 3: payload.push_back(cfg.quality_code);
            4:    payload.push_back(cfg.attn_code);
            5:    payload.push_back(cfg.medit_code);
            6:    payload.push_back(cfg.blink_code);
            7: begin
               if ($urandom_range(3) == 0) begin
                  payload.push_back(cfg.power_code);
                  repeat (POWER_ROW_BYTES - 1) payload.push_back(8'($urandom));
               end else begin
                  payload.push_back(8'($urandom));
               end
            end
            default: begin
               do b = 8'($urandom);
               while (b == cfg.raw_code || b == cfg.quality_code || b == cfg.attn_code ||
                      b == cfg.medit_code || b == cfg.blink_code || b == cfg.power_code);
               payload.push_back(b);
            end
         endcase
         if ($urandom_range(1)) payload.push_back(8'($urandom));
      end
      while (payload.size() > len) void'(payload.pop_back());
      send_frame($urandom_range(7) == 0, ($urandom_range(7) == 0) ? $urandom_range(2, 1) : 0);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      wait (results_due == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic program_regs(input cfg_type c);
      reg_index_type idx;
      idx = REG_SYNC;
      repeat (NUM_REGS) begin
         csr_write_en <= 1'b1;
         csr_index    <= idx;
         csr_wdata    <= c[(NUM_REGS - 1 - int'(idx)) * BYTE_W +: BYTE_W];
         @(negedge clock);
         idx = idx.next();
      end
      csr_write_en <= 1'b0;
      cfg = c;
   endtask

   task automatic run_setting(input cfg_type c, input int goal);
      settle();
      program_regs(c);
      while (sent_bytes < goal) random_frame();
   endtask

   initial begin
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_rx_byte  = '0;
      rsp_ready    = 1'b0;
      csr_write_en = 1'b0;
      csr_index    = REG_SYNC;
      csr_wdata    = '0;
      quiet_cycles = 0;
      sent_bytes   = 0;
      tx_idle_pct  = 7;
      rx_idle_pct  = 55;
      cfg          = RESET_CFG;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty payload
      payload.delete();
      send_frame(1'b0, 0);
      // every byte row, value extremes
      payload = {cfg.quality_code, 8'h00, cfg.attn_code, 8'hFF,
                 cfg.medit_code, 8'h80, cfg.blink_code, 8'h7F};
      send_frame(1'b0, 0);
      // raw rows, length byte ignored, last one wins
      payload = {cfg.raw_code, 8'h02, 8'h7F, 8'hFF, cfg.raw_code, 8'hFF, 8'h80, 8'h00};
      send_frame(1'b0, 0);
      payload = {cfg.quality_code, 8'h5A};
      send_frame(1'b1, 0);
      send_byte(cfg.sync_byte);
      send_byte(~cfg.sync_byte);
      // extra syncs, unknown code, row cut by end of payload
      payload = {8'h01, cfg.quality_code};
      send_frame(1'b0, 2);
      send_byte(cfg.sync_byte);
      send_byte(cfg.sync_byte);
      send_byte(8'hFF);

      while (sent_bytes < 350) random_frame();
      next_cfg = cfg_type'({$urandom, $urandom});
      next_cfg.max_payload = 8'($urandom_range(255, 4));
      run_setting(next_cfg, 650);

      tx_idle_pct = 55;
      rx_idle_pct = 7;
      next_cfg = '{sync_byte: 8'hFF, max_payload: 8'h00, raw_code: 8'h00,
                   quality_code: 8'h00, attn_code: 8'h00, medit_code: 8'h00,
                   blink_code: 8'h00, power_code: 8'h00};
      run_setting(next_cfg, 800);
      next_cfg = '{sync_byte: 8'h00, max_payload: 8'hFF, raw_code: 8'hFF,
                   quality_code: 8'h00, attn_code: 8'h80, medit_code: 8'h7F,
                   blink_code: 8'h01, power_code: 8'hFE};
      run_setting(next_cfg, 1300);

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      // shared codes resolve by priority
      next_cfg = RESET_CFG;
      next_cfg.quality_code = next_cfg.raw_code;
      next_cfg.power_code   = next_cfg.raw_code;
      next_cfg.medit_code   = next_cfg.attn_code;
      next_cfg.blink_code   = next_cfg.attn_code;
      run_setting(next_cfg, 1600);
      next_cfg = cfg_type'({$urandom, $urandom});
      next_cfg.max_payload = 8'($urandom_range(255, 4));
      run_setting(next_cfg, 1900);

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0) begin
         $display("eeg_headset_packet_parser regression: pass");
      end else begin
         $display("eeg_headset_packet_parser regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/eegpp_pkg.sv
rtl/eegpp_rows.sv
rtl/eegpp_frame.sv
rtl/eeg_headset_packet_parser.sv
rtl/eegpp_checker.sv
bench/eeg_headset_packet_parser_check.sv
bench/eeg_headset_packet_parser_test.sv
